// File: src/uapd_pkg.sv
// ----------------------------------------------------------------------------
// uapd_pkg
// Pattern tables, verdict codes and helpers for the URI attack detector.
// ----------------------------------------------------------------------------
package uapd_pkg;

    typedef enum logic [1:0] {
        VERDICT_CLEAN     = 2'd0,
        VERDICT_TRAVERSAL = 2'd1,
        VERDICT_SCRIPT    = 2'd2,
        VERDICT_SQL       = 2'd3
    } verdict_t;

    // Pattern lengths per class, all patterns of a class packed end to end
    localparam int TRAV_LEN   = 18;
    localparam int SCRIPT_LEN = 62;
    localparam int SQL_LEN    = 64;

    // Class hit bits
    localparam int HIT_TRAV   = 0;
    localparam int HIT_SCRIPT = 1;
    localparam int HIT_SQL    = 2;

    // Packed pattern text, first character in the most significant byte.
    // Traversal is case-sensitive; script and sql are stored folded (lower).
    localparam logic [8*TRAV_LEN-1:0] TRAV_TEXT = "../..\\%2e%2e%2E%2E";
    localparam logic [8*SCRIPT_LEN-1:0] SCRIPT_TEXT =
        "<script</script>javascript:onload=onerror=onclick=onmouseover=";
    localparam logic [8*SQL_LEN-1:0] SQL_TEXT =
        "' or  or 'union selectdrop tabledelete frominsert intoupdate set";

    // Bit k set where a pattern begins / ends at packed position k
    localparam logic [TRAV_LEN-1:0] TRAV_START =
        TRAV_LEN'((18'd1 << 0) | (18'd1 << 3) | (18'd1 << 6) | (18'd1 << 12));
    localparam logic [TRAV_LEN-1:0] TRAV_END =
        TRAV_LEN'((18'd1 << 2) | (18'd1 << 5) | (18'd1 << 11) | (18'd1 << 17));

    localparam logic [SCRIPT_LEN-1:0] SCRIPT_START =
        SCRIPT_LEN'((62'd1 << 0) | (62'd1 << 7) | (62'd1 << 16) | (62'd1 << 27) |
                    (62'd1 << 34) | (62'd1 << 42) | (62'd1 << 50));
    localparam logic [SCRIPT_LEN-1:0] SCRIPT_END =
        SCRIPT_LEN'((62'd1 << 6) | (62'd1 << 15) | (62'd1 << 26) | (62'd1 << 33) |
                    (62'd1 << 41) | (62'd1 << 49) | (62'd1 << 61));

    localparam logic [SQL_LEN-1:0] SQL_START =
        SQL_LEN'((64'd1 << 0) | (64'd1 << 5) | (64'd1 << 10) | (64'd1 << 22) |
                 (64'd1 << 32) | (64'd1 << 43) | (64'd1 << 54));
    localparam logic [SQL_LEN-1:0] SQL_END =
        SQL_LEN'((64'd1 << 4) | (64'd1 << 9) | (64'd1 << 21) | (64'd1 << 31) |
                 (64'd1 << 42) | (64'd1 << 53) | (64'd1 << 63));

    // ASCII fold: only 'A'..'Z' map to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] x);
        logic [7:0] y;
        y = x;
        if (x >= 8'h41 && x <= 8'h5A) begin
            y = x + 8'd32;
        end
        return y;
    endfunction

endpackage

// File: src/uri_attack_pattern_detector_top.sv
// ----------------------------------------------------------------------------
// uri_attack_pattern_detector_top
// Streaming URI scanner: traversal, script and SQL injection substrings.
// ----------------------------------------------------------------------------
// Takes one URI byte per item and runs three shift-and match vectors at once
// (traversal 18 bits, script 62 bits, sql 64 bits), one bit per pattern
// character. A full match sets a sticky class hit. On the item marked
// s_last one result item carries the verdict (traversal over script over
// sql, else clean) and all match state clears for the next URI; other items
// give no result. A zero byte ends the string and later bytes until s_last
// are ignored. Throughput is one item per cycle: the byte compare and vector
// shift are combinational in front of the match registers, and the result
// register lets a new item enter in the same cycle that m_ready takes the
// waiting verdict. m_valid rises in the cycle after the last byte is accepted.
// s_ready drops only while a verdict is held and m_ready is low.
// ----------------------------------------------------------------------------
module uri_attack_pattern_detector_top
    import uapd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_uri_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict,
    output logic       m_uri_ok
);

    // Match state
    logic [TRAV_LEN-1:0]   trav_reg,   trav_next;
    logic [SCRIPT_LEN-1:0] script_reg, script_next;
    logic [SQL_LEN-1:0]    sql_reg,    sql_next;
    logic [2:0]            hits_reg,   hits_next;
    logic                  ended_reg,  ended_next;

    // Result register
    logic       m_valid_reg, m_valid_next;
    verdict_t   verdict_reg, verdict_next;

    // Scan results for the current byte
    logic [TRAV_LEN-1:0]   trav_scan;
    logic [SCRIPT_LEN-1:0] script_scan;
    logic [SQL_LEN-1:0]    sql_scan;
    logic [2:0]            hits_all;
    logic [7:0]            byte_folded;
    logic                  accept;
    logic                  scan_en;

    assign s_ready     = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign scan_en     = !ended_reg && (s_uri_byte != 8'd0);
    assign byte_folded = fold_case(s_uri_byte);

    // Shift-and update: a bit matches if its character equals the byte and
    // it starts a pattern or the previous character of the pattern matched.
    always_comb begin
        for (int k = 0; k < TRAV_LEN; k++) begin
            trav_scan[k] = (TRAV_START[k] || (k > 0 && trav_reg[(k > 0) ? k - 1 : 0]))
                && (TRAV_TEXT[8*(TRAV_LEN-1-k) +: 8] == s_uri_byte);
        end
        for (int k = 0; k < SCRIPT_LEN; k++) begin
            script_scan[k] = (SCRIPT_START[k] ||
                              (k > 0 && script_reg[(k > 0) ? k - 1 : 0]))
                && (SCRIPT_TEXT[8*(SCRIPT_LEN-1-k) +: 8] == byte_folded);
        end
        for (int k = 0; k < SQL_LEN; k++) begin
            sql_scan[k] = (SQL_START[k] || (k > 0 && sql_reg[(k > 0) ? k - 1 : 0]))
                && (SQL_TEXT[8*(SQL_LEN-1-k) +: 8] == byte_folded);
        end
    end

    // Sticky hits including this byte
    always_comb begin
        hits_all = hits_reg;
        if (scan_en) begin
            hits_all[HIT_TRAV]   = hits_reg[HIT_TRAV]   || |(trav_scan & TRAV_END);
            hits_all[HIT_SCRIPT] = hits_reg[HIT_SCRIPT] || |(script_scan & SCRIPT_END);
            hits_all[HIT_SQL]    = hits_reg[HIT_SQL]    || |(sql_scan & SQL_END);
        end
    end

    always_comb begin
        trav_next    = trav_reg;
        script_next  = script_reg;
        sql_next     = sql_reg;
        hits_next    = hits_reg;
        ended_next   = ended_reg;
        m_valid_next = m_valid_reg;
        verdict_next = verdict_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            if (s_last) begin
                // Verdict by priority, then clear for the next URI
                m_valid_next = 1'b1;
                if (hits_all[HIT_TRAV]) begin
                    verdict_next = VERDICT_TRAVERSAL;
                end else if (hits_all[HIT_SCRIPT]) begin
                    verdict_next = VERDICT_SCRIPT;
                end else if (hits_all[HIT_SQL]) begin
                    verdict_next = VERDICT_SQL;
                end else begin
                    verdict_next = VERDICT_CLEAN;
                end
                trav_next   = '0;
                script_next = '0;
                sql_next    = '0;
                hits_next   = '0;
                ended_next  = 1'b0;
            end else if (!ended_reg) begin
                if (s_uri_byte == 8'd0) begin
                    ended_next = 1'b1;
                end else begin
                    trav_next   = trav_scan;
                    script_next = script_scan;
                    sql_next    = sql_scan;
                    hits_next   = hits_all;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trav_reg    <= '0;
            script_reg  <= '0;
            sql_reg     <= '0;
            hits_reg    <= '0;
            ended_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            trav_reg    <= trav_next;
            script_reg  <= script_next;
            sql_reg     <= sql_next;
            hits_reg    <= hits_next;
            ended_reg   <= ended_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = verdict_reg;
    assign m_uri_ok  = (verdict_reg == VERDICT_CLEAN);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> m_valid)
        else $error("last item did not produce a verdict");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> hits_reg == 3'd0 && !ended_reg
            && trav_reg == '0 && script_reg == '0 && sql_reg == '0)
        else $error("match state not cleared after last item");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last && !(m_valid && !m_ready) |=> !m_valid)
        else $error("verdict produced without a last item");

    a_ended_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        ended_reg && !(s_valid && s_ready && s_last) |=> $stable(hits_reg))
        else $error("hits changed after end of string");

endmodule

// File: verif/tb_uri_attack_pattern_detector_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uri_attack_pattern_detector_top
// Self-checking bench for the streaming URI attack pattern detector.
// ----------------------------------------------------------------------------
// URIs go in one byte per item through a bursty driver. A shift-and model of
// the three pattern classes predicts the verdict of every URI when its last
// byte is accepted. A monitor with its own stall pattern checks each verdict
// against the oldest prediction. The mix is mostly attack words (case
// scrambled, sometimes cut short) spliced into filler, plus early string
// ends and raw noise.
// ----------------------------------------------------------------------------
module tb_uri_attack_pattern_detector_top;
    import uapd_pkg::*;

    localparam int NPAT         = 18;   // 4 traversal, 7 script, 7 sql words
    localparam int RANDOM_ITEMS = 550;
    localparam int IDLE_LIMIT   = 2000; // cycles with no item moving on either side
    localparam int HOLDOFF_LEN  = 150;  // one long receiver hold-off

    typedef struct packed {
        logic [7:0] uri_byte;
        logic       last;
    } uri_item_t;

    typedef struct packed {
        verdict_t verdict;
        logic     uri_ok;
    } verdict_item_t;

    // Attack words, packed per class in the same order the block uses for its
    // match vectors; the index decides the class.
    string pat_text [NPAT] = '{
        "../", "..\\", "%2e%2e", "%2E%2E",
        "<script", "</script>", "javascript:", "onload=",
        "onerror=", "onclick=", "onmouseover=",
        "' or ", " or '", "union select", "drop table",
        "delete from", "insert into", "update set"
    };

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_uri_byte = 8'd0;
    logic       s_last     = 1'b0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [1:0] m_verdict;
    logic       m_uri_ok;

    uri_item_t     pending_bytes [$];
    verdict_item_t verdict_q [$];

    // Scanner model state
    logic [63:0] match_vec [3];
    logic [2:0]  class_hit;
    logic        str_ended;

    int error_count = 0;

    uri_attack_pattern_detector_top u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_uri_byte (s_uri_byte),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_verdict  (m_verdict),
        .m_uri_ok   (m_uri_ok)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------------
    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic int word_class(input int k);
        if (k < 4) begin
            return HIT_TRAV;
        end else if (k < 11) begin
            return HIT_SCRIPT;
        end
        return HIT_SQL;
    endfunction

    function automatic void clear_scan();
        for (int k = 0; k < 3; k++) begin
            match_vec[k] = 64'd0;
        end
        class_hit = 3'd0;
        str_ended = 1'b0;
    endfunction

    // One shift-and step over all words; bit positions run on per class
    function automatic void shift_and_step(input logic [7:0] c);
        logic [63:0] nxt [3];
        int          pos [3];
        int          cls;
        logic [7:0]  pc;
        logic [7:0]  cc;
        bit          chain;
        for (int k = 0; k < 3; k++) begin
            nxt[k] = 64'd0;
            pos[k] = 0;
        end
        for (int k = 0; k < NPAT; k++) begin
            cls = word_class(k);
            for (int j = 0; j < pat_text[k].len(); j++) begin
                pc = pat_text[k][j];
                cc = c;
                if (cls != HIT_TRAV) begin
                    pc = lower_ascii(pc);
                    cc = lower_ascii(cc);
                end
                chain = (j == 0) ? 1'b1 : match_vec[cls][pos[cls] - 1];
                if (chain && pc == cc) begin
                    nxt[cls][pos[cls]] = 1'b1;
                    if (j == pat_text[k].len() - 1) begin
                        class_hit[cls] = 1'b1;
                    end
                end
                pos[cls]++;
            end
        end
        for (int k = 0; k < 3; k++) begin
            match_vec[k] = nxt[k];
        end
    endfunction

    function automatic void predict_uri_byte(input logic [7:0] b, input logic last);
        verdict_item_t v;
        if (!str_ended) begin
            if (b == 8'd0) begin
                str_ended = 1'b1;
            end else begin
                shift_and_step(b);
            end
        end
        if (last) begin
            if (class_hit[HIT_TRAV]) begin
                v.verdict = VERDICT_TRAVERSAL;
            end else if (class_hit[HIT_SCRIPT]) begin
                v.verdict = VERDICT_SCRIPT;
            end else if (class_hit[HIT_SQL]) begin
                v.verdict = VERDICT_SQL;
            end else begin
                v.verdict = VERDICT_CLEAN;
            end
            v.uri_ok = (v.verdict == VERDICT_CLEAN);
            verdict_q.push_back(v);
            clear_scan();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic last);
        uri_item_t it;
        it.uri_byte = b;
        it.last     = last;
        pending_bytes.push_back(it);
    endtask

    task automatic push_text(input string s, input bit end_uri);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], end_uri && (i == s.len() - 1));
        end
    endtask

    // Random URI: segments of attack words (case scrambled, sometimes cut
    // short), filler from the pattern alphabet, stray zeros and raw noise.
    task automatic push_random_uri();
        logic [7:0] uri [$];
        logic [7:0] c;
        string      w;
        string      alphabet;
        int         nseg;
        int         r;
        int         k;
        int         wlen;
        alphabet = "./\\%2eE<>/:=' orsuniclptdfm";
        if ($urandom_range(0, 9) == 0) begin
            // pure noise, zeros included
            nseg = $urandom_range(1, 12);
            for (int i = 0; i < nseg; i++) begin
                uri.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            nseg = $urandom_range(1, 4);
            for (int s = 0; s < nseg; s++) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    k    = $urandom_range(0, NPAT - 1);
                    w    = pat_text[k];
                    wlen = w.len();
                    if ($urandom_range(0, 4) == 0) begin
                        wlen = $urandom_range(1, wlen - 1);
                    end
                    for (int i = 0; i < wlen; i++) begin
                        c = w[i];
                        if ($urandom_range(0, 1) && lower_ascii(c) >= "a"
                                && lower_ascii(c) <= "z") begin
                            c = c ^ 8'h20;
                        end
                        uri.push_back(c);
                    end
                end else if (r < 90) begin
                    repeat ($urandom_range(1, 4)) begin
                        uri.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
                    end
                end else if (r < 95) begin
                    uri.push_back(8'd0);
                end else begin
                    uri.push_back(8'($urandom_range(1, 255)));
                end
            end
        end
        for (int i = 0; i < uri.size(); i++) begin
            push_byte(uri[i], i == uri.size() - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of random length, random gaps; payload held while stalled
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_uri_byte(s_uri_byte, s_last);
                void'(pending_bytes.pop_front());
            end
            // a stalled item stays on the bus untouched
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    s_valid    <= 1'b1;
                    s_uri_byte <= pending_bytes[0].uri_byte;
                    s_last     <= pending_bytes[0].last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks verdicts; ready follows a randomly redrawn mode, plus one
    // long hold-off once enough verdicts have come back
    // ------------------------------------------------------------------------
    int  rx_mode       = 0;
    int  mode_cycles   = 0;
    int  verdicts_seen = 0;
    int  holdoff_left  = 0;
    bit  holdoff_done  = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("unexpected verdict item: verdict=%0d uri_ok=%0d",
                                 m_verdict, m_uri_ok);
                    end
                end else begin
                    if (m_verdict !== verdict_q[0].verdict
                            || m_uri_ok !== verdict_q[0].uri_ok) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display({"verdict mismatch: exp verdict=%0d uri_ok=%0d,",
                                      " got verdict=%0d uri_ok=%0d"},
                                     verdict_q[0].verdict, verdict_q[0].uri_ok,
                                     m_verdict, m_uri_ok);
                        end
                    end
                    void'(verdict_q.pop_front());
                end
            end

            mode_cycles++;
            if (mode_cycles >= 50) begin
                mode_cycles = 0;
                rx_mode     = $urandom_range(0, 3);
            end

            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else if (!holdoff_done && verdicts_seen >= 10) begin
                // long stall: sender keeps offering, block backs up
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_ready <= mode_cycles[0];
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with nothing moving on either channel
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("uri_attack_pattern_detector_top verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int target;
        clear_scan();

        // directed: each class, case folding, empty URI, high byte,
        // early string end hiding a traversal, two classes at once
        push_text("..\\", 1);
        push_byte(8'd0, 1);
        push_text("<ScRiPt", 1);
        push_text("' Or ", 1);
        push_byte(8'hFF, 1);
        push_text("a", 0);
        push_byte(8'd0, 0);
        push_text("../", 1);
        push_text("../' or ", 1);

        target = pending_bytes.size() + RANDOM_ITEMS;
        while (pending_bytes.size() < target) begin
            push_random_uri();
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() > 0 || verdict_q.size() > 0) begin
            @(posedge aclk);
        end
        // let any stray result show up before the final report
        repeat (6) @(posedge aclk);

        if (error_count == 0) begin
            $display("uri_attack_pattern_detector_top verification clean");
        end else begin
            $display("uri_attack_pattern_detector_top verification failed");
        end
        $finish;
    end

endmodule
